@@ rtl/ele_pkg.sv @@
// Shared types and constants for the echoing line editor.
`default_nettype none

package ele_pkg;

    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_DEL = 8'h7F;

    localparam logic [8:0] BUFFER_SIZE_RESET = 9'd64;

    // Kind of work one accepted byte turns into.
    typedef enum logic [3:0] {
        KIND_DROP    = 4'b0001,
        KIND_NEWLINE = 4'b0010,
        KIND_ERASE   = 4'b0100,
        KIND_CHAR    = 4'b1000
    } kind_t;

    // Everything the emitter needs to produce the results of one byte.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic [7:0] index;
        logic       done;
        logic [7:0] length;
    } plan_t;

endpackage

`default_nettype wire

@@ rtl/ele_decode.sv @@
// Decodes one received byte against the line count and capacity.
`default_nettype none

module ele_decode (
    input  wire logic [7:0]    rx_byte,
    input  wire logic [7:0]    char_count,
    input  wire logic [8:0]    buffer_size,
    output ele_pkg::plan_t     plan,
    output logic               plan_valid,
    output logic [7:0]         count_next
);

    logic [7:0] limit;
    logic [7:0] count_inc;

    always_comb
    begin
        if (buffer_size[8])
            limit = 8'd255;
        else if (buffer_size[7:0] == 8'd0)
            limit = 8'd0;
        else
            limit = buffer_size[7:0] - 8'd1;
    end

    assign count_inc = char_count + 8'd1;

    always_comb
    begin
        plan.kind   = ele_pkg::KIND_CHAR;
        plan.data   = rx_byte;
        plan.index  = char_count;
        plan.done   = 1'b0;
        plan.length = 8'd0;
        plan_valid  = 1'b1;
        count_next  = char_count;

        if (char_count >= limit) begin
            // The line is already full: the byte is dropped and the line ends.
            plan.kind   = ele_pkg::KIND_DROP;
            plan.done   = 1'b1;
            plan.length = char_count;
            count_next  = 8'd0;
        end else if (rx_byte == ele_pkg::CH_CR || rx_byte == ele_pkg::CH_LF) begin
            plan.kind   = ele_pkg::KIND_NEWLINE;
            plan.done   = 1'b1;
            plan.length = char_count;
            count_next  = 8'd0;
        end else if (rx_byte == ele_pkg::CH_BS || rx_byte == ele_pkg::CH_DEL) begin
            plan.kind = ele_pkg::KIND_ERASE;
            if (char_count == 8'd0)
                plan_valid = 1'b0;
            else
                count_next = char_count - 8'd1;
        end else if (count_inc >= limit) begin
            plan.done   = 1'b1;
            plan.length = count_inc;
            count_next  = 8'd0;
        end else begin
            count_next = count_inc;
        end
    end

endmodule

`default_nettype wire

@@ rtl/ele_emitter.sv @@
// Holds the plan of one byte and emits its result transactions one per cycle while the output does not stall.
`default_nettype none

module ele_emitter (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire ele_pkg::plan_t    plan,
    input  wire logic              plan_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   echo_valid,
    output logic [7:0]             echo_byte,
    output logic                   store_valid,
    output logic [7:0]             store_index,
    output logic [7:0]             store_byte,
    output logic                   line_done,
    output logic [7:0]             line_length,
    output logic                   last
);

    logic           busy_reg;
    logic           busy_next;
    logic [1:0]     beat_reg;
    logic [1:0]     beat_next;
    ele_pkg::plan_t plan_reg;
    logic           out_fire;

    assign out_valid = busy_reg;
    assign out_fire  = busy_reg && !out_stall;
    assign in_stall  = busy_reg && !(out_fire && last);

    always_comb
    begin
        echo_valid  = 1'b0;
        echo_byte   = 8'd0;
        store_valid = 1'b0;
        store_index = 8'd0;
        store_byte  = 8'd0;
        line_done   = 1'b0;
        line_length = 8'd0;
        last        = 1'b0;
        case (plan_reg.kind)
            ele_pkg::KIND_DROP:
            begin
                line_done   = 1'b1;
                line_length = plan_reg.length;
                last        = 1'b1;
            end
            ele_pkg::KIND_NEWLINE:
            begin
                echo_valid = 1'b1;
                if (beat_reg == 2'd0) begin
                    echo_byte = ele_pkg::CH_CR;
                end else begin
                    echo_byte   = ele_pkg::CH_LF;
                    line_done   = 1'b1;
                    line_length = plan_reg.length;
                    last        = 1'b1;
                end
            end
            ele_pkg::KIND_ERASE:
            begin
                echo_valid = 1'b1;
                if (beat_reg == 2'd1) begin
                    echo_byte = ele_pkg::CH_SP;
                end else begin
                    echo_byte = ele_pkg::CH_BS;
                end
                last = (beat_reg == 2'd2);
            end
            ele_pkg::KIND_CHAR:
            begin
                echo_valid  = 1'b1;
                echo_byte   = plan_reg.data;
                store_valid = 1'b1;
                store_index = plan_reg.index;
                store_byte  = plan_reg.data;
                line_done   = plan_reg.done;
                line_length = plan_reg.length;
                last        = 1'b1;
            end
            default:
            begin
                last = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        beat_next = beat_reg;
        if (out_fire) begin
            if (last)
                busy_next = 1'b0;
            else
                beat_next = beat_reg + 2'd1;
        end
        if (accept && plan_valid) begin
            busy_next = 1'b1;
            beat_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            beat_reg <= 2'd0;
        end else begin
            busy_reg <= busy_next;
            beat_reg <= beat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && plan_valid)
            plan_reg <= plan;
    end

endmodule

`default_nettype wire

@@ rtl/echoing_line_editor.sv @@
// Top level of the echoing line editor: count and capacity registers, decode and emitter.
// A result transaction is presented in the cycle after its byte is accepted.
// An ordinary byte yields one transaction, a newline two, an erase three; an
// erase on an empty line yields no transaction.
// The emitter has a single plan register, so the next byte is taken in the same
// cycle as the last transaction of the current one.
// Reset clears the line count, empties the emitter and sets buffer_size to 64.
`default_nettype none

module echoing_line_editor (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [8:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            echo_valid,
    output logic [7:0]      echo_byte,
    output logic            store_valid,
    output logic [7:0]      store_index,
    output logic [7:0]      store_byte,
    output logic            line_done,
    output logic [7:0]      line_length,
    output logic            last
);

    // Capacity register; the user must write it only while idle, the block does not enforce this.
    logic [8:0]     buffer_size_reg;
    // Number of characters in the line being edited.
    logic [7:0]     char_count_reg;
    logic [7:0]     char_count_next;
    ele_pkg::plan_t plan;
    logic           plan_valid;
    logic           accept;

    // A byte is taken whenever the emitter is empty or is finishing its last transaction.
    assign accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            buffer_size_reg <= ele_pkg::BUFFER_SIZE_RESET;
        end else if (cfg_we) begin
            buffer_size_reg <= cfg_data;
        end
    end

    // The count moves as soon as a byte is accepted, so the following byte sees it
    // even while earlier echo transactions are still waiting at the output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            char_count_reg <= 8'd0;
        end else if (accept) begin
            char_count_reg <= char_count_next;
        end
    end

    ele_decode u_decode (
        .rx_byte     (rx_byte),
        .char_count  (char_count_reg),
        .buffer_size (buffer_size_reg),
        .plan        (plan),
        .plan_valid  (plan_valid),
        .count_next  (char_count_next)
    );

    ele_emitter u_emitter (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .plan        (plan),
        .plan_valid  (plan_valid),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .echo_valid  (echo_valid),
        .echo_byte   (echo_byte),
        .store_valid (store_valid),
        .store_index (store_index),
        .store_byte  (store_byte),
        .line_done   (line_done),
        .line_length (line_length),
        .last        (last)
    );

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for the echoing line editor: scoreboard class, stimulus and checks.
module testbench;

    // The run is stopped by the watchdog if it goes past this many clock cycles.
    localparam int CYCLE_LIMIT = 200000;
    // Cycles the receiver holds off in one stretch to fill the block and stall its input.
    localparam int LONG_HOLD_CYCLES = 400;
    // Accepted bytes after which the long hold-off starts.
    localparam int LONG_HOLD_START = 100;
    // Quiet cycles after the last expected transaction; covers an erase on an empty line.
    localparam int SETTLE_CYCLES = 4;
    // Random phase whose capacity is large enough that only a long run fills a line.
    localparam int LONG_PHASE = 7;
    // Bytes sent in the long phase and in every other random phase.
    localparam int LONG_PHASE_ITEMS  = 290;
    localparam int SHORT_PHASE_ITEMS = 14;
    // Bytes of the long phase drawn as mostly printable to fill the line.
    localparam int LONG_RUN_ITEMS = 280;

    // One result transaction, field for field as the block presents it.
    typedef struct packed {
        logic       echo_valid;
        logic [7:0] echo_byte;
        logic       store_valid;
        logic [7:0] store_index;
        logic [7:0] store_byte;
        logic       line_done;
        logic [7:0] line_length;
        logic       last;
    } editor_result_t;

    // The scoreboard keeps its own copy of the line count and the capacity register,
    // predicts the transactions of every accepted byte and checks those that come out.
    class echo_scoreboard;
        logic [8:0]     capacity;
        logic [7:0]     line_count;
        editor_result_t expected_echoes[$];
        int             errors;

        function new();
            capacity   = ele_pkg::BUFFER_SIZE_RESET;
            line_count = 8'd0;
            errors     = 0;
        endfunction

        function void set_capacity(logic [8:0] value);
            capacity = value;
        endfunction

        function void push_echo(logic ev, logic [7:0] eb, logic sv, logic [7:0] si,
                                logic [7:0] sb, logic ld, logic [7:0] ll, logic lst);
            editor_result_t r;
            r.echo_valid  = ev;
            r.echo_byte   = eb;
            r.store_valid = sv;
            r.store_index = si;
            r.store_byte  = sb;
            r.line_done   = ld;
            r.line_length = ll;
            r.last        = lst;
            expected_echoes.push_back(r);
        endfunction

        // Predicts what one accepted byte causes and updates the line count.
        function void note_byte(logic [7:0] c);
            int         cap;
            int         limit;
            logic [7:0] slot;
            cap   = (capacity > 9'd256) ? 256 : int'(capacity);
            limit = (cap >= 1) ? cap - 1 : 0;
            if (int'(line_count) >= limit) begin
                // The line is already full, so the byte is dropped and the line ends.
                push_echo(1'b0, 8'd0, 1'b0, 8'd0, 8'd0, 1'b1, line_count, 1'b1);
                line_count = 8'd0;
            end else if (c == ele_pkg::CH_CR || c == ele_pkg::CH_LF) begin
                push_echo(1'b1, ele_pkg::CH_CR, 1'b0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0);
                push_echo(1'b1, ele_pkg::CH_LF, 1'b0, 8'd0, 8'd0, 1'b1, line_count, 1'b1);
                line_count = 8'd0;
            end else if (c == ele_pkg::CH_BS || c == ele_pkg::CH_DEL) begin
                if (line_count != 8'd0) begin
                    line_count = line_count - 8'd1;
                    push_echo(1'b1, ele_pkg::CH_BS, 1'b0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0);
                    push_echo(1'b1, ele_pkg::CH_SP, 1'b0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0);
                    push_echo(1'b1, ele_pkg::CH_BS, 1'b0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b1);
                end
            end else begin
                slot       = line_count;
                line_count = line_count + 8'd1;
                if (int'(line_count) >= limit) begin
                    push_echo(1'b1, c, 1'b1, slot, c, 1'b1, line_count, 1'b1);
                    line_count = 8'd0;
                end else begin
                    push_echo(1'b1, c, 1'b1, slot, c, 1'b0, 8'd0, 1'b1);
                end
            end
        endfunction

        task report_mismatch(string what);
            if (errors < 100)
                $display("MISMATCH at %0t: %s", $time, what);
            errors++;
        endtask

        task check_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
        endtask

        task check_result(editor_result_t got);
            editor_result_t want;
            if (expected_echoes.size() == 0) begin
                report_mismatch("result transaction with nothing expected");
            end else begin
                want = expected_echoes.pop_front();
                check_field("echo_valid", 8'(got.echo_valid), 8'(want.echo_valid));
                check_field("echo_byte", got.echo_byte, want.echo_byte);
                check_field("store_valid", 8'(got.store_valid), 8'(want.store_valid));
                check_field("store_index", got.store_index, want.store_index);
                check_field("store_byte", got.store_byte, want.store_byte);
                check_field("line_done", 8'(got.line_done), 8'(want.line_done));
                check_field("line_length", got.line_length, want.line_length);
                check_field("last", 8'(got.last), 8'(want.last));
            end
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [8:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_stall;
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       store_valid;
    logic [7:0] store_index;
    logic [7:0] store_byte;
    logic       line_done;
    logic [7:0] line_length;
    logic       last;

    echo_scoreboard board;

    // Set by the stimulus for phases that run with no idling on either side.
    logic no_idle;
    // Set by the hold-off process while the receiver refuses every transaction.
    logic hold_off;
    int   accepted_bytes;
    int   cycle_count;

    echoing_line_editor i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .echo_valid  (echo_valid),
        .echo_byte   (echo_byte),
        .store_valid (store_valid),
        .store_index (store_index),
        .store_byte  (store_byte),
        .line_done   (line_done),
        .line_length (line_length),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // The watchdog counts cycles and ends a run that hangs.
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Offers one byte after a random gap and waits until the block takes it. The valid
    // stays high after acceptance; the next call either keeps it up for a back-to-back
    // transaction or lowers it, so it gets one assignment per time step.
    task automatic send_byte(input logic [7:0] value);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // The transaction was accepted at this edge, so its results can be predicted.
        board.note_byte(value);
        accepted_bytes++;
    endtask

    // Drops the input valid and waits until every predicted transaction has come out.
    // A settling wait then lets an erase on an empty line, which yields nothing, finish.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.expected_echoes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the capacity register while the block is idle.
    task automatic write_capacity(input logic [8:0] value);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        board.set_capacity(value);
        cfg_we <= 1'b0;
    endtask

    // Draws a random byte. Most bytes are printable, so lines grow and reach the limit;
    // erases, newlines and fully random bytes make up the rest. In long-line mode only
    // a rare erase breaks the run of printable bytes, so even the largest buffer fills.
    function automatic logic [7:0] pick_byte(input bit long_line);
        int roll;
        roll = $urandom_range(0, 99);
        if (long_line)
        begin
            if (roll < 2)
                return (roll == 0) ? ele_pkg::CH_BS : ele_pkg::CH_DEL;
            return 8'($urandom_range(32'h20, 32'h7E));
        end
        if (roll < 60)
            return 8'($urandom_range(32'h20, 32'h7E));
        if (roll < 72)
            return (roll < 66) ? ele_pkg::CH_BS : ele_pkg::CH_DEL;
        if (roll < 82)
            return (roll < 77) ? ele_pkg::CH_CR : ele_pkg::CH_LF;
        return 8'($urandom_range(0, 255));
    endfunction

    // The receiver draws a stall length after every accepted result and counts it down.
    // During the long hold-off it stalls regardless. The outputs are sampled at the edge,
    // before the block updates them.
    initial
    begin : result_sink
        int             stall_left;
        editor_result_t got;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                got.echo_valid  = echo_valid;
                got.echo_byte   = echo_byte;
                got.store_valid = store_valid;
                got.store_index = store_index;
                got.store_byte  = store_byte;
                got.line_done   = line_done;
                got.line_length = line_length;
                got.last        = last;
                board.check_result(got);
                stall_left = no_idle ? 0 : $urandom_range(0, 19);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
            end
            out_stall <= (stall_left > 0) || hold_off;
        end
    end

    // Once the traffic is under way, the receiver holds off for a long stretch while
    // the sender keeps offering bytes, so the block fills up and stalls its input.
    initial
    begin : receiver_hold
        hold_off <= 1'b0;
        @(posedge clk);
        while (accepted_bytes < LONG_HOLD_START)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin : stimulus
        int         caps [10];
        int         cap;
        int         items;
        bit         long_phase;
        logic [8:0] cap_value;
        caps = '{3, 256, 2, 257, 17, 0, 255, 511, 1, 40};

        board          = new();
        accepted_bytes = 0;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_data  <= 9'd0;
        in_valid  <= 1'b0;
        rx_byte   <= 8'd0;
        out_stall <= 1'b0;
        no_idle   <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, starting with the reset capacity of 64.
        // Erases on an empty line produce nothing at all.
        send_byte(ele_pkg::CH_BS);
        send_byte(ele_pkg::CH_DEL);
        // Ordinary bytes at the extremes of the byte range are echoed and stored.
        send_byte(8'h41);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(ele_pkg::CH_SP);
        // Both erase codes remove a character and echo backspace, space, backspace.
        send_byte(ele_pkg::CH_BS);
        send_byte(ele_pkg::CH_DEL);
        // Both newline codes end the line with CR then LF.
        send_byte(ele_pkg::CH_CR);
        send_byte(8'h7E);
        send_byte(ele_pkg::CH_LF);
        // Three characters, then the capacity shrinks under the open line: the next
        // byte is dropped and ends the line with the old count.
        send_byte(8'h70);
        send_byte(8'h71);
        send_byte(8'h72);
        write_capacity(9'd2);
        send_byte(8'h7A);
        // With room for one character, a single byte fills and ends the line.
        send_byte(8'h6B);
        send_byte(ele_pkg::CH_CR);
        // A capacity below two drops every byte, erases included.
        write_capacity(9'd0);
        send_byte(8'h55);
        send_byte(ele_pkg::CH_BS);
        write_capacity(9'd1);
        send_byte(ele_pkg::CH_LF);
        // A capacity above 256 behaves as 256.
        write_capacity(9'h1FF);
        send_byte(8'h31);
        send_byte(ele_pkg::CH_CR);

        // Random part: one phase per capacity setting, the extremes among them.
        for (int p = 0; p < 12; p++)
        begin
            if (p < 10)
                cap = caps[p];
            else if (p == 10)
                cap = $urandom_range(2, 256);
            else
                cap = $urandom_range(0, 511);
            cap_value = 9'(cap);
            write_capacity(cap_value);
            no_idle <= (p % 4 == 3);
            // One phase with the largest capacity runs long enough to fill a line.
            long_phase = (p == LONG_PHASE);
            items = long_phase ? LONG_PHASE_ITEMS : SHORT_PHASE_ITEMS;
            for (int k = 0; k < items; k++)
                send_byte(pick_byte(long_phase && k < LONG_RUN_ITEMS));
        end
        no_idle <= 1'b0;

        wait_idle();
        if (board.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
